[src/elt_pkg.sv]
// Shared types and codes of the edge list table.
`default_nettype none

package elt_pkg;

  // Fixed field widths of the beats on both channels
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned VTX_W     = 10;
  localparam int unsigned WEIGHT_W  = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CNT_OUT_W = 7;

  // Default table depth
  localparam int unsigned DEF_MAX_EDGES = 64;

  typedef logic [MODE_W-1:0]    mode_t;
  typedef logic [VTX_W-1:0]     vtx_t;
  typedef logic [WEIGHT_W-1:0]  weight_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CNT_OUT_W-1:0] cnt_out_t;

  // Operation codes
  localparam mode_t MODE_ADD        = mode_t'(0);
  localparam mode_t MODE_REMOVE     = mode_t'(1);
  localparam mode_t MODE_REMOVE_MIN = mode_t'(2);
  localparam mode_t MODE_QUERY      = mode_t'(3);

  // Status codes
  localparam status_t STAT_DONE     = status_t'(0);
  localparam status_t STAT_DUP      = status_t'(1);
  localparam status_t STAT_NOTFOUND = status_t'(2);
  localparam status_t STAT_EMPTY    = status_t'(3);
  localparam status_t STAT_FULL     = status_t'(4);

  typedef struct packed {
    mode_t   mode;
    vtx_t    origin_vertex;
    vtx_t    dest_vertex;
    weight_t edge_weight;
  } in_t;

  typedef struct packed {
    status_t  status;
    vtx_t     affected_origin;
    vtx_t     affected_dest;
    cnt_out_t affected_id;
    cnt_out_t degree;
  } out_t;

endpackage

`default_nettype wire

[src/edge_list_table.sv]
// Edge list table: bounded list of edges held in a single entry memory.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (out_t)
//
// An accepted beat is scanned against every entry, one scan read a cycle through the single
// read port with a registered read; a removal then moves newer entries down one slot a cycle.
// A query skips the scan. The input stalls while an operation or its pending result is in flight.
// Reset clears the fill count and control, never the entry memory.
// A stalled output holds its beat; a finished result waits until the register frees.
`default_nettype none

module edge_list_table #(
  parameter int unsigned MAX_EDGES = elt_pkg::DEF_MAX_EDGES
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output      logic         in_stall_o,
  input  wire elt_pkg::in_t in_data_i,
  output      logic         out_valid_o,
  input  wire logic         out_stall_i,
  output elt_pkg::out_t     out_data_o
);

  localparam int unsigned AddrW = $clog2(MAX_EDGES);
  localparam int unsigned CntW  = $clog2(MAX_EDGES + 1);

  typedef logic [AddrW-1:0] idx_t;
  typedef logic [CntW-1:0]  cnt_t;

  // One stored edge
  typedef struct packed {
    elt_pkg::vtx_t    origin;
    elt_pkg::vtx_t    dest;
    elt_pkg::weight_t weight;
    cnt_t             id;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  // Entry memory, slot 0 oldest
  entry_t mem_q [MAX_EDGES];
  entry_t rd_q;

  logic   mem_we;
  logic   mem_re;
  idx_t   mem_waddr;
  idx_t   mem_raddr;
  entry_t mem_wdata;

  state_e         state_q, state_d;
  cnt_t           len_q, len_d;
  cnt_t           rd_idx_q, rd_idx_d;     // next slot to read
  logic           cmp_vld_q, cmp_vld_d;   // rd_q holds slot cmp_idx_q this cycle
  idx_t           cmp_idx_q, cmp_idx_d;
  logic           hit_q, hit_d;
  idx_t           hit_idx_q, hit_idx_d;
  entry_t         hit_ent_q, hit_ent_d;
  elt_pkg::in_t   op_q, op_d;
  elt_pkg::out_t  res_q, res_d;
  elt_pkg::out_t  out_q, out_d;
  logic           out_valid_q, out_valid_d;

  logic scan_end;
  logic pair_match;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_raddr];
    end
  end

  assign scan_end   = (rd_idx_q == len_q) && !cmp_vld_q;
  assign pair_match = (rd_q.origin == op_q.origin_vertex) && (rd_q.dest == op_q.dest_vertex);

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    op_d        = op_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = '0;
    mem_raddr   = rd_idx_q[AddrW-1:0];
    mem_wdata   = '0;

    // Drop the output beat once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d     = in_data_i;
          hit_d    = 1'b0;
          rd_idx_d = '0;
          if (in_data_i.mode == elt_pkg::MODE_QUERY) begin
            res_d   = '0;
            res_d.status = elt_pkg::STAT_DONE;
            res_d.degree = elt_pkg::cnt_out_t'(len_q);
            state_d = ST_RESP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read
        if (rd_idx_q != len_q) begin
          mem_re    = 1'b1;
          rd_idx_d  = rd_idx_q + cnt_t'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[AddrW-1:0];
        end
        // Examine the slot read last cycle; later hits overwrite, so newest wins
        if (cmp_vld_q) begin
          if (op_q.mode == elt_pkg::MODE_REMOVE_MIN) begin
            if (!hit_q || (rd_q.dest <= hit_ent_q.dest)) begin
              hit_d     = 1'b1;
              hit_idx_d = cmp_idx_q;
              hit_ent_d = rd_q;
            end
          end else if (pair_match) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            hit_ent_d = rd_q;
          end
        end
        if (scan_end) begin
          res_d = '0;
          res_d.degree = elt_pkg::cnt_out_t'(len_q);
          state_d = ST_RESP;
          case (op_q.mode)
            elt_pkg::MODE_ADD: begin
              if (hit_q) begin
                res_d.status = elt_pkg::STAT_DUP;
              end else if (len_q == cnt_t'(MAX_EDGES)) begin
                res_d.status = elt_pkg::STAT_FULL;
              end else begin
                mem_we           = 1'b1;
                mem_waddr        = len_q[AddrW-1:0];
                mem_wdata.origin = op_q.origin_vertex;
                mem_wdata.dest   = op_q.dest_vertex;
                mem_wdata.weight = op_q.edge_weight;
                mem_wdata.id     = len_q + cnt_t'(1);
                len_d            = len_q + cnt_t'(1);
                res_d.status          = elt_pkg::STAT_DONE;
                res_d.affected_origin = op_q.origin_vertex;
                res_d.affected_dest   = op_q.dest_vertex;
                res_d.affected_id     = elt_pkg::cnt_out_t'(len_q + cnt_t'(1));
                res_d.degree          = elt_pkg::cnt_out_t'(len_q + cnt_t'(1));
              end
            end
            elt_pkg::MODE_REMOVE, elt_pkg::MODE_REMOVE_MIN: begin
              if (!hit_q) begin
                res_d.status = (op_q.mode == elt_pkg::MODE_REMOVE) ?
                               elt_pkg::STAT_NOTFOUND : elt_pkg::STAT_EMPTY;
              end else begin
                res_d.status          = elt_pkg::STAT_DONE;
                res_d.affected_origin = hit_ent_q.origin;
                res_d.affected_dest   = hit_ent_q.dest;
                res_d.affected_id     = elt_pkg::cnt_out_t'(hit_ent_q.id);
                res_d.degree          = elt_pkg::cnt_out_t'(len_q - cnt_t'(1));
                rd_idx_d              = cnt_t'(hit_idx_q) + cnt_t'(1);
                state_d               = ST_SHIFT;
              end
            end
            default: begin
              res_d.status = elt_pkg::STAT_DONE;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // Read slot i, write it back to slot i-1 in the next cycle
        if (rd_idx_q != len_q) begin
          mem_re    = 1'b1;
          rd_idx_d  = rd_idx_q + cnt_t'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[AddrW-1:0];
        end
        if (cmp_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_q - idx_t'(1);
          mem_wdata = rd_q;
        end
        if (scan_end) begin
          len_d   = len_q - cnt_t'(1);
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= '0;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_ent_q   <= '0;
      op_q        <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      hit_ent_q   <= hit_ent_d;
      op_q        <= op_d;
      res_q       <= res_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // Fill count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= cnt_t'(MAX_EDGES))
    else $error("fill count above table depth");

  // Memory writes only during a scan or compaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_SCAN || state_q == ST_SHIFT))
    else $error("memory write outside scan or compaction");

  // An accepted beat starts work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q != ST_IDLE))
    else $error("accepted beat did not start an operation");

  // A result beat only appears from the response state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
    else $error("result beat without a finished operation");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench of the edge list table: directed and random operations.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned MAX_EDGES   = elt_pkg::DEF_MAX_EDGES;
  // Longest operation is a full scan plus a full compaction; allow a margin on top.
  localparam int unsigned SETTLE_CYCLES = 2 * MAX_EDGES + 32;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned DRAIN_LIMIT   = 200000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  elt_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  elt_pkg::out_t out_data_o;

  edge_list_table uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Chance in percent that the sender idles or the receiver stalls in a cycle.
  int unsigned idle_pct = 33;
  int unsigned stall_pct = 33;

  // Bump to ask the receiver for one long hold-off.
  int unsigned hold_serial = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned mismatch_count = 0;
  int unsigned result_index = 0;

  // Expected result beats, oldest first.
  elt_pkg::out_t expected_results[$];

  // Shadow of the edge table, slot 0 oldest, slot tbl_len-1 newest.
  elt_pkg::vtx_t    tbl_origin [MAX_EDGES];
  elt_pkg::vtx_t    tbl_dest   [MAX_EDGES];
  elt_pkg::weight_t tbl_weight [MAX_EDGES];
  elt_pkg::cnt_out_t tbl_id    [MAX_EDGES];
  int unsigned tbl_len = 0;
  int unsigned id_count = 0;

  // Search newest first; -1 when the pair is absent.
  function automatic int find_edge(elt_pkg::vtx_t o, elt_pkg::vtx_t d);
    for (int i = int'(tbl_len) - 1; i >= 0; i--) begin
      if (tbl_origin[i] == o && tbl_dest[i] == d) return i;
    end
    return -1;
  endfunction

  // Drop slot k, shift the newer entries down and count the edge out.
  function automatic void drop_edge(int unsigned k);
    for (int unsigned i = k; i + 1 < tbl_len; i++) begin
      tbl_origin[i] = tbl_origin[i+1];
      tbl_dest[i]   = tbl_dest[i+1];
      tbl_weight[i] = tbl_weight[i+1];
      tbl_id[i]     = tbl_id[i+1];
    end
    tbl_len--;
    if (id_count > 0) id_count--;
  endfunction

  // Apply one operation beat to the shadow table and return the result beat it causes.
  function automatic elt_pkg::out_t apply_edge_op(elt_pkg::in_t b);
    elt_pkg::out_t r;
    int   k;
    int unsigned best;
    r = '0;
    r.status = elt_pkg::STAT_DONE;
    case (b.mode)
      elt_pkg::MODE_ADD: begin
        if (find_edge(b.origin_vertex, b.dest_vertex) >= 0) begin
          r.status = elt_pkg::STAT_DUP;
        end else if (tbl_len >= MAX_EDGES) begin
          r.status = elt_pkg::STAT_FULL;
        end else begin
          id_count++;
          tbl_origin[tbl_len] = b.origin_vertex;
          tbl_dest[tbl_len]   = b.dest_vertex;
          tbl_weight[tbl_len] = b.edge_weight;
          tbl_id[tbl_len]     = elt_pkg::cnt_out_t'(id_count);
          tbl_len++;
          r.affected_origin = b.origin_vertex;
          r.affected_dest   = b.dest_vertex;
          r.affected_id     = elt_pkg::cnt_out_t'(id_count);
        end
      end
      elt_pkg::MODE_REMOVE: begin
        k = find_edge(b.origin_vertex, b.dest_vertex);
        if (k < 0) begin
          r.status = elt_pkg::STAT_NOTFOUND;
        end else begin
          r.affected_origin = tbl_origin[k];
          r.affected_dest   = tbl_dest[k];
          r.affected_id     = tbl_id[k];
          drop_edge(unsigned'(k));
        end
      end
      elt_pkg::MODE_REMOVE_MIN: begin
        if (tbl_len == 0) begin
          r.status = elt_pkg::STAT_EMPTY;
        end else begin
          // Strict compare while walking toward older slots keeps the newest on ties.
          best = tbl_len - 1;
          for (int i = int'(tbl_len) - 2; i >= 0; i--) begin
            if (tbl_dest[i] < tbl_dest[best]) best = unsigned'(i);
          end
          r.affected_origin = tbl_origin[best];
          r.affected_dest   = tbl_dest[best];
          r.affected_id     = tbl_id[best];
          drop_edge(best);
        end
      end
      default: ;
    endcase
    r.degree = elt_pkg::cnt_out_t'(tbl_len);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    $display("mismatch at result %0d: %s got %0d expected %0d (%0t)",
             result_index, what, got, want, $realtime);
  endtask

  // Offer one beat; hold it until accepted, then predict its result.
  task automatic send_op(elt_pkg::mode_t m, elt_pkg::vtx_t o, elt_pkg::vtx_t d,
                         elt_pkg::weight_t w);
    elt_pkg::in_t b;
    b.mode          = m;
    b.origin_vertex = o;
    b.dest_vertex   = d;
    b.edge_weight   = w;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_results.push_back(apply_edge_op(b));
  endtask

  // Receiver: random stalls, or one long hold-off when asked for it.
  always @(posedge clk_i) begin
    if (hold_seen != hold_serial) begin
      hold_seen   <= hold_serial;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    elt_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", 32'd1, 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        if (out_data_o.affected_origin !== want.affected_origin)
          report_mismatch("affected_origin", 32'(out_data_o.affected_origin),
                          32'(want.affected_origin));
        if (out_data_o.affected_dest !== want.affected_dest)
          report_mismatch("affected_dest", 32'(out_data_o.affected_dest),
                          32'(want.affected_dest));
        if (out_data_o.affected_id !== want.affected_id)
          report_mismatch("affected_id", 32'(out_data_o.affected_id),
                          32'(want.affected_id));
        if (out_data_o.degree !== want.degree)
          report_mismatch("degree", 32'(out_data_o.degree), 32'(want.degree));
      end
      result_index++;
    end
  end

  // Query, remove-min and remove on a list that holds nothing yet.
  task automatic test_empty_list();
    send_op(elt_pkg::MODE_QUERY, '0, '0, '0);
    send_op(elt_pkg::MODE_REMOVE_MIN, '1, '1, '1);
    send_op(elt_pkg::MODE_REMOVE, '0, '0, '0);
  endtask

  // Field extremes, duplicate add, absent and present removes, gap closing.
  task automatic test_extremes_and_duplicates();
    send_op(elt_pkg::MODE_ADD, 10'd0, 10'd0, 32'h0000_0000);
    send_op(elt_pkg::MODE_ADD, 10'd1023, 10'd1023, 32'hFFFF_FFFF);
    send_op(elt_pkg::MODE_ADD, 10'd0, 10'd0, 32'h3F80_0000);      // duplicate pair
    send_op(elt_pkg::MODE_ADD, 10'd0, 10'd1023, 32'h8000_0001);
    send_op(elt_pkg::MODE_ADD, 10'd1023, 10'd0, 32'h7FFF_FFFF);
    send_op(elt_pkg::MODE_REMOVE, 10'd512, 10'd512, '0);          // absent pair
    send_op(elt_pkg::MODE_REMOVE, 10'd1023, 10'd1023, '0);        // middle slot
    send_op(elt_pkg::MODE_QUERY, 10'h2AA, 10'h155, 32'hA5A5_5A5A);
    send_op(elt_pkg::MODE_REMOVE, 10'd0, 10'd1023, '0);
    send_op(elt_pkg::MODE_REMOVE, 10'd0, 10'd0, '0);              // oldest slot
    send_op(elt_pkg::MODE_REMOVE_MIN, '0, '0, '0);
    send_op(elt_pkg::MODE_REMOVE_MIN, '0, '0, '0);                // empty again
  endtask

  // Equal smallest destinations: the newest one must go first.
  task automatic test_min_ties();
    send_op(elt_pkg::MODE_ADD, 10'd4, 10'd9, $urandom);
    send_op(elt_pkg::MODE_ADD, 10'd5, 10'd2, $urandom);
    send_op(elt_pkg::MODE_ADD, 10'd6, 10'd2, $urandom);
    send_op(elt_pkg::MODE_ADD, 10'd7, 10'd2, $urandom);
    send_op(elt_pkg::MODE_ADD, 10'd8, 10'd9, $urandom);
    repeat (5) send_op(elt_pkg::MODE_REMOVE_MIN, '0, '0, '0);
  endtask

  // Fill to capacity, overflow, then drain back to empty with no gaps at all.
  task automatic test_fill_and_overflow();
    elt_pkg::vtx_t o, d;
    while (tbl_len < MAX_EDGES) begin
      o = elt_pkg::vtx_t'($urandom);
      d = elt_pkg::vtx_t'($urandom);
      if (find_edge(o, d) < 0) send_op(elt_pkg::MODE_ADD, o, d, $urandom);
    end
    do begin
      o = elt_pkg::vtx_t'($urandom);
      d = elt_pkg::vtx_t'($urandom);
    end while (find_edge(o, d) >= 0);
    send_op(elt_pkg::MODE_ADD, o, d, $urandom);                        // full, dropped
    send_op(elt_pkg::MODE_ADD, tbl_origin[7], tbl_dest[7], $urandom);  // duplicate wins
    send_op(elt_pkg::MODE_QUERY, o, d, $urandom);
    send_op(elt_pkg::MODE_REMOVE, tbl_origin[0], tbl_dest[0], '0);
    send_op(elt_pkg::MODE_ADD, o, d, $urandom);
    idle_pct  = 0;
    stall_pct = 0;
    while (tbl_len > 0) send_op(elt_pkg::MODE_REMOVE_MIN, '0, '0, '0);
    send_op(elt_pkg::MODE_REMOVE_MIN, '0, '0, '0);
    idle_pct  = 33;
    stall_pct = 33;
  endtask

  // Hold the output off for a long stretch while beats keep coming in.
  task automatic test_output_holdoff();
    hold_serial <= hold_serial + 1;
    idle_pct = 0;
    repeat (3) send_op(elt_pkg::MODE_ADD, elt_pkg::vtx_t'($urandom_range(7)),
                       elt_pkg::vtx_t'($urandom_range(7)), $urandom);
    repeat (3) send_op(elt_pkg::MODE_QUERY, '0, '0, '0);
    repeat (4) send_op(elt_pkg::MODE_REMOVE_MIN, '0, '0, '0);
    idle_pct = 33;
  endtask

  // Random traffic that grows toward full and shrinks toward empty in turn.
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned pick, k;
    bit   grow;
    elt_pkg::vtx_t o, d;
    grow = 1'b1;
    for (int unsigned i = 0; i < n_items; i++) begin
      // One long stretch with no idling on either side.
      if (i == n_items / 3) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      if (i == n_items / 3 + 100) begin
        idle_pct  = 33;
        stall_pct = 33;
      end
      if (tbl_len == 0) grow = 1'b1;
      else if (tbl_len >= MAX_EDGES && $urandom_range(1)) grow = 1'b0;
      else if ($urandom_range(99) < 2) grow = !grow;

      // Small pools make duplicates and destination ties common.
      o = $urandom_range(1) ? elt_pkg::vtx_t'($urandom_range(7)) : elt_pkg::vtx_t'($urandom);
      d = $urandom_range(1) ? elt_pkg::vtx_t'($urandom_range(7)) : elt_pkg::vtx_t'($urandom);
      pick = $urandom_range(99);
      if (pick < (grow ? 60 : 20)) begin
        if (tbl_len > 0 && $urandom_range(99) < 15) begin
          k = $urandom_range(tbl_len - 1);
          o = tbl_origin[k];
          d = tbl_dest[k];
        end
        send_op(elt_pkg::MODE_ADD, o, d, $urandom);
      end else if (pick < (grow ? 80 : 60)) begin
        if (tbl_len > 0 && $urandom_range(99) < 75) begin
          k = $urandom_range(tbl_len - 1);
          o = tbl_origin[k];
          d = tbl_dest[k];
        end
        send_op(elt_pkg::MODE_REMOVE, o, d, $urandom);
      end else if (pick < (grow ? 92 : 90)) begin
        send_op(elt_pkg::MODE_REMOVE_MIN, o, d, $urandom);
      end else begin
        send_op(elt_pkg::MODE_QUERY, o, d, $urandom);
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_extremes_and_duplicates();
    test_min_ties();
    test_fill_and_overflow();
    test_output_holdoff();
    test_random_traffic(230);

    in_valid_i <= 1'b0;
    // Wait for every outstanding result, then let the block settle.
    for (int n = 0; n < DRAIN_LIMIT && expected_results.size() != 0; n++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("result beats never delivered", 32'd0, 32'(expected_results.size()));

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
